// ----- design/ctns_pkg.sv -----
// Shared constants and types for the click/noise test source.
`default_nettype none

package ctns_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_SOURCE_MODE    = 3'd0,
        CFG_AUTO_TRIGGER   = 3'd1,
        CFG_TRIGGER_PERIOD = 3'd2,
        CFG_CLICK_LENGTH   = 3'd3,
        CFG_NOISE_LENGTH   = 3'd4
    } t_cfg_idx;

    // Source mode codes; either code with the top bit set selects external
    localparam logic [1:0] MODE_CLICK = 2'd0;
    localparam logic [1:0] MODE_NOISE = 2'd1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] LCG_SEED  = 32'd1;
    // First value the generator yields after reset (seed advanced once)
    localparam logic [31:0] LCG_FIRST = 32'(LCG_SEED * LCG_MUL + LCG_ADD);

    localparam logic [15:0] CLICK_SCALE     = 16'd200;
    localparam logic [15:0] CLICK_CEIL      = 16'd28000;
    localparam logic [15:0] CLICK_CEIL_STEP = 16'd140;   // CLICK_CEIL / CLICK_SCALE
    localparam logic [15:0] CLICK_MIN       = 16'd4;
    localparam logic [15:0] CLICK_STARTUP   = 16'd110;

    localparam logic [1:0]  RST_SOURCE_MODE    = MODE_CLICK;
    localparam logic        RST_AUTO_TRIGGER   = 1'b1;
    localparam logic [23:0] RST_TRIGGER_PERIOD = 24'd33075;
    localparam logic [15:0] RST_CLICK_LENGTH   = 16'd110;
    localparam logic [15:0] RST_NOISE_LENGTH   = 16'd4410;

endpackage

`default_nettype wire

// ----- design/ctns_lcg.sv -----
// Look-ahead LCG noise generator with recentring and 3/8 scaling.
`default_nettype none

module ctns_lcg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    output logic signed [15:0] o_noise
);
    import ctns_pkg::*;

    // r_state holds the value the next noise word will use
    logic [31:0] r_state;
    logic [31:0] n_state;
    logic [17:0] w_v_ext;
    logic [17:0] w_v3;

    always_comb begin
        n_state = r_state * LCG_MUL + LCG_ADD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LCG_FIRST;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    // top half minus 32768 is the top half with its msb flipped
    always_comb begin
        w_v_ext = {{2{~r_state[31]}}, ~r_state[31], r_state[30:16]};
        w_v3    = w_v_ext + {w_v_ext[16:0], 1'b0};
        o_noise = {w_v3[17], w_v3[17:3]};
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_state))
        else $error("lcg state moved without advance");

    a_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> r_state != $past(r_state))
        else $error("lcg state failed to move on advance");

endmodule

`default_nettype wire

// ----- design/click_noise_test_source_core.sv -----
// Click / noise / pass-through test source, top level.
`default_nettype none

// One word in, one sample word out. An input word is taken every cycle while
// the output register is empty or being drained in the same cycle, so the
// sustained rate is one sample per clock, and each sample word is registered. All
// burst, phase and LCG state is updated in the accept cycle; the longest paths
// run through the 32-bit phase add and period compare into the click reload
// and scaling, and through the 32-bit LCG multiply into the generator state.
// Configuration writes take effect at once and must only happen while idle.
module click_noise_test_source_core #(
    parameter int BLOCK_SAMPLES = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [ctns_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [ctns_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_manual_trigger,
    input  wire logic signed [15:0]                  i_dry_sample,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [15:0]                       o_sample
);
    import ctns_pkg::*;

    localparam int BP_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam logic [BP_W-1:0] BP_LAST = BP_W'(BLOCK_SAMPLES - 1);
    localparam logic [31:0]     PHASE_STEP = 32'(BLOCK_SAMPLES);

    // configuration
    logic [1:0]  r_mode;
    logic        r_auto;
    logic [23:0] r_period;
    logic [15:0] r_click_len;
    logic [15:0] r_noise_len;

    // state
    logic [31:0]     r_phase,  n_phase;
    logic [15:0]     r_click,  n_click;
    logic [15:0]     r_noise,  n_noise;
    logic [BP_W-1:0] r_bpos,   n_bpos;
    logic            r_out_valid;
    logic [15:0]     r_sample, n_sample;

    logic        w_accept;
    logic        w_gen;
    logic        w_is_noise;
    logic [15:0] w_click_start;
    logic [31:0] w_phase_add;
    logic        w_advance;
    logic signed [15:0] w_noise;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_gen       = !r_mode[1];    // either code with bit 1 set is external
    assign w_is_noise  = (r_mode == MODE_NOISE);
    assign w_click_start = (r_click_len < CLICK_MIN) ? CLICK_MIN : r_click_len;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_SOURCE_MODE;
            r_auto      <= RST_AUTO_TRIGGER;
            r_period    <= RST_TRIGGER_PERIOD;
            r_click_len <= RST_CLICK_LENGTH;
            r_noise_len <= RST_NOISE_LENGTH;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SOURCE_MODE:    r_mode      <= i_cfg_wdata[1:0];
                CFG_AUTO_TRIGGER:   r_auto      <= i_cfg_wdata[0];
                CFG_TRIGGER_PERIOD: r_period    <= i_cfg_wdata;
                CFG_CLICK_LENGTH:   r_click_len <= i_cfg_wdata[15:0];
                CFG_NOISE_LENGTH:   r_noise_len <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_click     = r_click;
        n_noise     = r_noise;
        n_sample    = 16'd0;
        w_advance   = 1'b0;
        w_phase_add = 32'd0;

        if (!w_gen) begin
            n_sample = i_dry_sample;
        end else begin
            // manual trigger first
            if (i_manual_trigger) begin
                n_phase = 32'd0;
                if (w_is_noise) begin
                    n_noise = r_noise_len;
                end else begin
                    n_click = w_click_start;
                end
            end
            // automatic retrigger, checked at block starts only
            w_phase_add = n_phase + PHASE_STEP;
            if (r_bpos == '0 && r_auto) begin
                n_phase = w_phase_add;
                if (w_phase_add >= {8'd0, r_period}) begin
                    n_phase = 32'd0;
                    if (w_is_noise) begin
                        n_noise = r_noise_len;
                    end else begin
                        n_click = w_click_start;
                    end
                end
            end
            if (n_click != 16'd0) begin
                n_sample = (n_click > CLICK_CEIL_STEP) ? CLICK_CEIL
                         : n_click * CLICK_SCALE;
                n_click  = n_click - 16'd1;
            end
            // noise overrides a still-sounding click
            if (w_is_noise && n_noise != 16'd0) begin
                w_advance = 1'b1;
                n_sample  = w_noise;
                n_noise   = n_noise - 16'd1;
            end
        end

        n_bpos = (r_bpos == BP_LAST) ? '0 : r_bpos + BP_W'(1);
    end

    ctns_lcg u_lcg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_accept && w_advance),
        .o_noise   (w_noise)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 32'd0;
            r_click     <= CLICK_STARTUP;
            r_noise     <= 16'd0;
            r_bpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_click <= n_click;
                r_noise <= n_noise;
                r_bpos  <= n_bpos;
            end
            // hold the word until taken, refill on accept
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= n_sample;
        end
    end

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word did not reach the output register");

    a_ext_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_gen) |=>
            ($stable(r_click) && $stable(r_noise) && $stable(r_phase)))
        else $error("burst state moved in external mode");

    // away from an automatic check the phase must read zero after the reload
    a_click_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_gen && !w_is_noise && i_manual_trigger
            && (r_bpos != '0 || !r_auto)) |=>
            (r_click == $past(w_click_start) - 16'd1) && (r_phase == 32'd0))
        else $error("manual click trigger did not reload the burst");

    a_block_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_bpos == BP_LAST) |=> r_bpos == '0)
        else $error("block position failed to wrap");

endmodule

`default_nettype wire
